[rtl/csvt_pkg.sv]
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and character codes shared by the CSV field tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	localparam int unsigned CHAR_BITS = 16;

	localparam logic [CHAR_BITS-1:0] CH_QUOTE = 16'h0022;
	localparam logic [CHAR_BITS-1:0] CH_COMMA = 16'h002C;
	localparam logic [CHAR_BITS-1:0] CH_CR    = 16'h000D;
	localparam logic [CHAR_BITS-1:0] CH_LF    = 16'h000A;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_FIELD  = 2'd1,
		KIND_RECORD = 2'd2
	} kind_t;

	// Parser flags kept between words
	typedef struct packed {
		logic quote_mode;
		logic quote_pending;
		logic skip_linefeed;
		logic field_has_chars;
	} flags_t;

	// Queue entry control part; the field indexes travel beside it.
	// A second result, when present, is always an end of record.
	typedef struct packed {
		logic                  two;
		kind_t                 kind0;
		logic [CHAR_BITS-1:0]  char0;
	} ent_ctl_t;

endpackage

`default_nettype wire

[rtl/csvt_if.sv]
// ----------------------------------------------------------------------------
// csvt_if
// Valid/ready channels of the CSV field tokenizer: text in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface csvt_out_if #(
	parameter int unsigned IDX_W = 8
);
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [15:0]      char_out;
	logic [IDX_W-1:0] field_index;
	logic             last_of_run;

	modport source (output valid, output kind, output char_out, output field_index,
		output last_of_run, input ready);
	modport sink   (input valid, input kind, input char_out, input field_index,
		input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/csv_field_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Streaming comma-separated text tokenizer: one code unit per word in,
// field characters, end of field and end of record tokens out.
//
//   port    dir  payload                                       role
//   text    in   char_code[15:0], is_last                      text code units
//   token   out  kind[1:0], char_out[15:0], field_index,       tokens
//                last_of_run
//
// One text word is accepted per cycle while the four-entry queue has room.
// The output register sends one token per cycle while token.ready is high;
// two tokens of one word go out in turn; the queue absorbs that. Tokens pass
// the queue, then the output register. Reset clears parser state, queue and
// output valid at once; no clearing pass. Either side may stall without loss.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_unit #(
	parameter int unsigned FIELD_INDEX_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	csvt_in_if.sink     text,
	csvt_out_if.source  token
);

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned CTL_W   = $bits(csvt_pkg::ent_ctl_t);
	localparam int unsigned ENT_W   = CTL_W + 2 * FIELD_INDEX_BITS;

	logic                        push, pop, q_full, q_empty;
	csvt_pkg::ent_ctl_t          f_ctl, b_ctl;
	logic [FIELD_INDEX_BITS-1:0] f_idx0, f_idx1, b_idx0, b_idx1;
	logic [ENT_W-1:0]            q_wdata, q_rdata;
	csvt_pkg::flags_t            status;

	csvt_front #(.IDX_W(FIELD_INDEX_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.q_full (q_full),
		.push   (push),
		.ctl    (f_ctl),
		.idx0   (f_idx0),
		.idx1   (f_idx1),
		.status (status)
	);

	assign q_wdata = {f_ctl, f_idx0, f_idx1};

	csvt_queue #(.DATA_W(ENT_W), .DEPTH(Q_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_ctl, b_idx0, b_idx1} = q_rdata;

	csvt_back #(.IDX_W(FIELD_INDEX_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.ctl        (b_ctl),
		.idx0       (b_idx0),
		.idx1       (b_idx1),
		.pop        (pop),
		.token      (token)
	);

	// parser state starts over after the final word of a text
	a_last_resets : assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready && text.is_last |=> status == '0)
		else $error("parser state not cleared after final word");

	// a pending quote and a pending linefeed skip never coexist
	a_pend_skip : assert property (@(posedge clk) disable iff (!arst_n)
		!(status.quote_pending && status.skip_linefeed))
		else $error("quote pending together with linefeed skip");

	// only character tokens carry a character
	a_char_zero : assert property (@(posedge clk) disable iff (!arst_n)
		token.valid && (token.kind != csvt_pkg::KIND_CHAR) |-> token.char_out == '0)
		else $error("non-character token carries a character");

	// a pop never happens on an empty queue
	a_pop_empty : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule

`default_nettype wire

[rtl/csvt_front.sv]
// ----------------------------------------------------------------------------
// csvt_front
// Accepts text words, tracks quoting and field position, and pushes the
// results of each word (zero, one or two) as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_front #(
	parameter int unsigned IDX_W = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	csvt_in_if.sink              text,
	input  wire                  q_full,
	output logic                 push,
	output csvt_pkg::ent_ctl_t   ctl,
	output logic [IDX_W-1:0]     idx0,
	output logic [IDX_W-1:0]     idx1,
	output csvt_pkg::flags_t     status
);

	csvt_pkg::flags_t   flags_q;
	logic [IDX_W-1:0]   pos_q;

	csvt_pkg::flags_t   st_n;
	logic [IDX_W-1:0]   pos_n;
	logic [IDX_W-1:0]   pos1;
	logic               hc1;
	logic               r0v;
	csvt_pkg::kind_t    r0_kind;
	logic [15:0]        r0_char;
	logic               rec2;

	logic accept;
	logic is_quote, is_comma, is_cr, is_lf;
	logic skip_hit, pair, qm_m;

	assign text.ready = !q_full;
	assign accept     = text.valid && text.ready;

	assign is_quote = text.char_code == csvt_pkg::CH_QUOTE;
	assign is_comma = text.char_code == csvt_pkg::CH_COMMA;
	assign is_cr    = text.char_code == csvt_pkg::CH_CR;
	assign is_lf    = text.char_code == csvt_pkg::CH_LF;

	// LF right after a record-ending CR is eaten
	assign skip_hit = flags_q.skip_linefeed && is_lf;
	// doubled quote inside quotes
	assign pair     = !skip_hit && flags_q.quote_pending && is_quote;
	// a pending quote that is not doubled closes the quoted section
	assign qm_m     = flags_q.quote_mode && !flags_q.quote_pending;

	always_comb begin
		st_n               = flags_q;
		st_n.skip_linefeed = 1'b0;
		pos1               = pos_q;
		hc1                = flags_q.field_has_chars;
		r0v                = 1'b0;
		r0_kind            = csvt_pkg::KIND_CHAR;
		r0_char            = '0;

		if (pair) begin
			r0v                = 1'b1;
			r0_char            = csvt_pkg::CH_QUOTE;
			hc1                = 1'b1;
			st_n.quote_pending = 1'b0;
		end else if (!skip_hit) begin
			st_n.quote_pending = 1'b0;
			st_n.quote_mode    = qm_m;
			if (is_quote) begin
				if (qm_m && !text.is_last) begin
					st_n.quote_pending = 1'b1;
				end else begin
					st_n.quote_mode = !qm_m;
				end
			end else if (is_comma && !qm_m) begin
				r0v     = 1'b1;
				r0_kind = csvt_pkg::KIND_FIELD;
				pos1    = (pos_q == '1) ? pos_q : pos_q + 1'b1;
				hc1     = 1'b0;
			end else if ((is_cr || is_lf) && !qm_m) begin
				r0v                = (pos_q != '0) || flags_q.field_has_chars;
				r0_kind            = csvt_pkg::KIND_RECORD;
				pos1               = '0;
				hc1                = 1'b0;
				st_n.skip_linefeed = is_cr && !text.is_last;
			end else begin
				r0v     = 1'b1;
				r0_char = text.char_code;
				hc1     = 1'b1;
			end
		end

		// final word flushes the record
		rec2                 = text.is_last && ((pos1 != '0) || hc1);
		st_n.field_has_chars = hc1;
		pos_n                = pos1;
		if (text.is_last) begin
			st_n  = '0;
			pos_n = '0;
		end

		push      = accept && (r0v || rec2);
		ctl.two   = r0v && rec2;
		ctl.kind0 = r0v ? r0_kind : csvt_pkg::KIND_RECORD;
		ctl.char0 = r0v ? r0_char : '0;
		idx0      = r0v ? pos_q : pos1;
		idx1      = pos1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			flags_q <= st_n;
			pos_q   <= pos_n;
		end
	end

	assign status = flags_q;

endmodule

`default_nettype wire

[rtl/csvt_queue.sv]
// ----------------------------------------------------------------------------
// csvt_queue
// Small first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_queue #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wire  [DATA_W-1:0] wdata,
	input  wire               pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/csvt_back.sv]
// ----------------------------------------------------------------------------
// csvt_back
// Unpacks queue entries into single results and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_back #(
	parameter int unsigned IDX_W = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  csvt_pkg::ent_ctl_t   ctl,
	input  wire  [IDX_W-1:0]     idx0,
	input  wire  [IDX_W-1:0]     idx1,
	output logic                 pop,
	csvt_out_if.source           token
);

	logic                out_valid_q;
	csvt_pkg::kind_t     kind_q;
	logic [15:0]         char_q;
	logic [IDX_W-1:0]    idx_q;
	logic                last_q;
	logic                sel_q;
	logic                load;

	assign load = head_valid && (!out_valid_q || token.ready);
	// release the entry once its final result is loaded
	assign pop  = load && (sel_q || !ctl.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= !pop;
			end else if (token.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sel_q) begin
				kind_q <= csvt_pkg::KIND_RECORD;
				char_q <= '0;
				idx_q  <= idx1;
				last_q <= 1'b1;
			end else begin
				kind_q <= ctl.kind0;
				char_q <= ctl.char0;
				idx_q  <= idx0;
				last_q <= !ctl.two;
			end
		end
	end

	assign token.valid       = out_valid_q;
	assign token.kind        = kind_q;
	assign token.char_out    = char_q;
	assign token.field_index = idx_q;
	assign token.last_of_run = last_q;

endmodule

`default_nettype wire

[bench/csv_field_tokenizer_unit_test.sv]
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit_test
// Self-checking bench for the CSV field tokenizer. Text code units go in over
// the text channel and each accepted word is run through a behavioral
// tokenizer held in a scoreboard. Tokens leaving the block are compared field
// by field, in order, with the predicted ones. A short directed pass hits the
// quoting corner cases, then random texts (mostly well-formed records, some
// noise) run with random stalls on both channels, except in a final calm stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_unit_test;

	localparam int unsigned IDX_W        = 8;
	localparam int          RANDOM_WORDS = 1650;
	localparam int          CALM_WORDS   = 1400;
	localparam int          STALL_LIMIT  = 1000;
	localparam int          SHOWN_MAX    = 10;

	localparam logic [15:0] CH_LOW_A = 16'h0061;
	localparam logic [15:0] CH_SUB   = 16'h005F;

	typedef struct packed {
		csvt_pkg::kind_t  kind;
		logic [15:0]      code;
		logic [IDX_W-1:0] index;
		logic             run_end;
	} token_t;

	typedef struct packed {
		logic        fin;
		logic [15:0] code;
	} unit_t;

	class csv_token_board;
		token_t           expected_tokens[$];
		logic             in_quotes;
		logic             quote_wait;
		logic             eat_lf;
		logic             field_started;
		logic [IDX_W-1:0] field_no;
		int               words_noted;
		int               tokens_checked;
		int               records_seen;
		int               top_index;
		int               failures;

		function new();
			restart();
			words_noted = 0;
			tokens_checked = 0;
			records_seen = 0;
			top_index = 0;
			failures = 0;
		endfunction

		function void restart();
			in_quotes = 1'b0;
			quote_wait = 1'b0;
			eat_lf = 1'b0;
			field_started = 1'b0;
			field_no = '0;
		endfunction

		function void push_token(csvt_pkg::kind_t k, logic [15:0] c);
			expected_tokens.push_back('{kind: k, code: c, index: field_no, run_end: 1'b0});
		endfunction

		function void close_field();
			push_token(csvt_pkg::KIND_FIELD, 16'h0000);
			if (field_no != {IDX_W{1'b1}})
				field_no++;
			field_started = 1'b0;
		endfunction

		// drop a record that is one empty field
		function void close_record();
			if (field_no != 0 || field_started)
				push_token(csvt_pkg::KIND_RECORD, 16'h0000);
			field_no = '0;
			field_started = 1'b0;
		endfunction

		// tokenize one accepted text word
		function void note_word(logic [15:0] c, logic fin);
			int  before_cnt;
			bit  handled;
			before_cnt = expected_tokens.size();
			handled = 1'b0;
			words_noted++;
			if (eat_lf) begin
				eat_lf = 1'b0;
				if (c == csvt_pkg::CH_LF)
					handled = 1'b1;
			end
			if (!handled && quote_wait) begin
				quote_wait = 1'b0;
				if (c == csvt_pkg::CH_QUOTE) begin
					push_token(csvt_pkg::KIND_CHAR, csvt_pkg::CH_QUOTE);
					field_started = 1'b1;
					handled = 1'b1;
				end else begin
					in_quotes = 1'b0;
				end
			end
			if (!handled) begin
				if (c == csvt_pkg::CH_QUOTE) begin
					if (in_quotes && !fin)
						quote_wait = 1'b1;
					else
						in_quotes = !in_quotes;
				end else if (c == csvt_pkg::CH_COMMA && !in_quotes) begin
					close_field();
				end else if ((c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF) && !in_quotes) begin
					close_record();
					if (c == csvt_pkg::CH_CR && !fin)
						eat_lf = 1'b1;
				end else begin
					push_token(csvt_pkg::KIND_CHAR, c);
					field_started = 1'b1;
				end
			end
			if (fin) begin
				close_record();
				restart();
			end
			if (expected_tokens.size() > before_cnt)
				expected_tokens[expected_tokens.size()-1].run_end = 1'b1;
		endfunction

		function void check_token(token_t got);
			token_t exp;
			tokens_checked++;
			if (got.kind == csvt_pkg::KIND_RECORD)
				records_seen++;
			if (int'(got.index) > top_index)
				top_index = int'(got.index);
			if (expected_tokens.size() == 0) begin
				failures++;
				if (failures <= SHOWN_MAX)
					$display("token %0d unexpected: kind %0d code %h index %0d end %0b",
						tokens_checked, got.kind, got.code, got.index, got.run_end);
				return;
			end
			exp = expected_tokens.pop_front();
			if (got.kind !== exp.kind || got.code !== exp.code ||
				got.index !== exp.index || got.run_end !== exp.run_end) begin
				failures++;
				if (failures <= SHOWN_MAX)
					$display({"token %0d mismatch: expected kind %0d code %h index %0d end %0b,",
						" got kind %0d code %h index %0d end %0b"}, tokens_checked,
						exp.kind, exp.code, exp.index, exp.run_end,
						got.kind, got.code, got.index, got.run_end);
			end
		endfunction

		function void close_out();
			if (expected_tokens.size() != 0) begin
				failures += expected_tokens.size();
				$display("%0d expected tokens never arrived", expected_tokens.size());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   gap_odds;
	int   random_words;
	int   texts_sent;

	unit_t          text_units[$];
	csv_token_board board = new();

	csvt_in_if                    text_ch();
	csvt_out_if #(.IDX_W(IDX_W))  token_ch();

	csv_field_tokenizer_unit #(
		.FIELD_INDEX_BITS(IDX_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.token(token_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- text side ----

	task automatic send_word(logic [15:0] c, logic fin);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.char_code <= c;
		text_ch.is_last   <= fin;
		@(posedge clk);
		while (text_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic send_text();
		foreach (text_units[i]) begin
			send_word(text_units[i].code, text_units[i].fin);
			random_words++;
		end
		text_units.delete();
		texts_sent++;
	endtask

	function automatic void put_unit(logic [15:0] c);
		text_units.push_back('{fin: 1'b0, code: c});
	endfunction

	// any code unit that is not a delimiter or a quote
	function automatic logic [15:0] plain_char();
		logic [15:0] c;
		case ($urandom_range(0, 9))
			0, 1:    c = 16'($urandom_range(0, 16'hFFFF));
			2:       c = 16'($urandom_range(16'hFF00, 16'hFFFF));
			default: c = 16'($urandom_range(16'h0020, 16'h007E));
		endcase
		if (c == csvt_pkg::CH_QUOTE || c == csvt_pkg::CH_COMMA ||
			c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF)
			c = CH_SUB;
		return c;
	endfunction

	function automatic void put_field();
		case ($urandom_range(0, 3))
			0: ;
			1, 2: begin
				repeat ($urandom_range(1, 6))
					put_unit(plain_char());
			end
			default: begin
				put_unit(csvt_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 9))
						0, 1: begin
							put_unit(csvt_pkg::CH_QUOTE);
							put_unit(csvt_pkg::CH_QUOTE);
						end
						2:       put_unit(csvt_pkg::CH_COMMA);
						3:       put_unit(csvt_pkg::CH_CR);
						4:       put_unit(csvt_pkg::CH_LF);
						default: put_unit(plain_char());
					endcase
				end
				put_unit(csvt_pkg::CH_QUOTE);
			end
		endcase
	endfunction

	function automatic void put_record_end();
		case ($urandom_range(0, 2))
			0: put_unit(csvt_pkg::CH_CR);
			1: put_unit(csvt_pkg::CH_LF);
			default: begin
				put_unit(csvt_pkg::CH_CR);
				put_unit(csvt_pkg::CH_LF);
			end
		endcase
	endfunction

	function automatic void build_text();
		int records;
		records = $urandom_range(1, 4);
		for (int r = 0; r < records; r++) begin
			if ($urandom_range(0, 7) != 0) begin
				for (int f = $urandom_range(1, 6); f > 0; f--) begin
					put_field();
					if (f > 1)
						put_unit(csvt_pkg::CH_COMMA);
				end
			end
			if (r < records - 1 || $urandom_range(0, 1) != 0)
				put_record_end();
		end
		if (text_units.size() == 0)
			put_unit(csvt_pkg::CH_LF);
		text_units[text_units.size()-1].fin = 1'b1;
	endfunction

	// broken quoting, stray delimiters and raw code units
	function automatic void build_noise();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 5))
				0:       put_unit(csvt_pkg::CH_QUOTE);
				1:       put_unit(csvt_pkg::CH_COMMA);
				2:       put_unit(csvt_pkg::CH_CR);
				3:       put_unit(csvt_pkg::CH_LF);
				4:       put_unit(16'($urandom_range(0, 16'hFFFF)));
				default: put_unit(plain_char());
			endcase
		end
		if ($urandom_range(0, 1) != 0)
			text_units[text_units.size()-1].fin = 1'b1;
	endfunction

	// one record with more fields than the index can count
	function automatic void build_wide_record();
		for (int f = 0; f < 300; f++) begin
			if ($urandom_range(0, 3) == 0)
				put_unit(plain_char());
			put_unit(csvt_pkg::CH_COMMA);
		end
		put_unit(CH_LOW_A);
		put_unit(csvt_pkg::CH_LF);
		text_units[text_units.size()-1].fin = 1'b1;
	endfunction

	// ---- token side ----

	initial begin
		token_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			token_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				token_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
				board.note_word(text_ch.char_code, text_ch.is_last);
			if (token_ch.valid === 1'b1 && token_ch.ready === 1'b1)
				board.check_token('{kind: csvt_pkg::kind_t'(token_ch.kind),
					code: token_ch.char_out, index: token_ch.field_index,
					run_end: token_ch.last_of_run});
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_ch.valid === 1'b1 && text_ch.ready === 1'b1) ||
				(token_ch.valid === 1'b1 && token_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("no word moved for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ---- main sequence ----

	initial begin
		bit wide_done;
		wide_done = 1'b0;
		calm = 1'b0;
		gap_odds = 0;
		random_words = 0;
		texts_sent = 0;
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.char_code <= '0;
		text_ch.is_last <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: code extremes, quoting corners, suppressed records, flushes
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(csvt_pkg::CH_COMMA, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(csvt_pkg::CH_COMMA, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(16'h0071, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(csvt_pkg::CH_CR, 1'b0);
		send_word(csvt_pkg::CH_LF, 1'b0);
		send_word(csvt_pkg::CH_LF, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(csvt_pkg::CH_CR, 1'b0);
		send_word(csvt_pkg::CH_LF, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(16'h007A, 1'b0);
		send_word(csvt_pkg::CH_CR, 1'b0);
		send_word(csvt_pkg::CH_QUOTE, 1'b1);
		send_word(16'h0062, 1'b0);
		send_word(csvt_pkg::CH_COMMA, 1'b0);
		send_word(csvt_pkg::CH_CR, 1'b1);
		send_word(csvt_pkg::CH_QUOTE, 1'b0);
		send_word(16'h0078, 1'b1);
		send_word(csvt_pkg::CH_LF, 1'b1);

		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			calm = random_words >= CALM_WORDS;
			case ($urandom_range(0, 2))
				0:       gap_odds = 0;
				1:       gap_odds = 3;
				default: gap_odds = 8;
			endcase
			if (!wide_done && random_words >= 500) begin
				build_wide_record();
				wide_done = 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				build_noise();
			end else begin
				build_text();
			end
			send_text();
		end
		text_ch.valid <= 1'b0;

		// drain, then give a stray token time to show up
		while (board.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		board.close_out();

		$display("Ran %0d texts: %0d words in, %0d tokens checked, %0d records closed,",
			texts_sent, board.words_noted, board.tokens_checked, board.records_seen);
		$display("highest field index %0d, %0d failures", board.top_index, board.failures);
		if (board.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
